// File: rtl/can_frame_crc16_framer_unit_assert.svh
// Assertion macros for the CAN log framer.
// Depends on nothing; included by the top level only.
`ifndef CAN_FRAME_CRC16_FRAMER_UNIT_ASSERT_SVH
`define CAN_FRAME_CRC16_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CRCFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer check failed");

// Next-cycle implication, disabled while reset is high.
`define CRCFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer check failed");

`endif

// File: rtl/crcfr_pkg.sv
// Shared types and constants for the CAN log framer.
// Depends on nothing; used by every module of the block.
package crcfr_pkg;

   localparam int FRAME_LEN     = 24;
   localparam int PAYLOAD_LEN   = 20;
   localparam int CHAIN_LEN     = PAYLOAD_LEN + 2;
   localparam int POS_W         = $clog2(FRAME_LEN);

   localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND = 8'h55;
   localparam logic [15:0] CRC_SEED    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;

   // Frame positions of the payload span and the two CRC bytes.
   localparam logic [POS_W-1:0] PAYLOAD_FIRST_POS = POS_W'(2);
   localparam logic [POS_W-1:0] PAYLOAD_LAST_POS  = POS_W'(PAYLOAD_LEN + 1);
   localparam logic [POS_W-1:0] CRC_LO_POS        = POS_W'(FRAME_LEN - 2);
   localparam logic [POS_W-1:0] LAST_POS          = POS_W'(FRAME_LEN - 1);

   typedef struct packed {
      logic [31:0] msg_id;
      logic [7:0]  id_kind;
      logic [7:0]  frame_kind;
      logic [7:0]  length_code;
      logic [63:0] data_bytes;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   // Control for the byte cells: parallel load wins over shift.
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   // Control for the CRC cell: clear wins over update.
   typedef struct packed {
      logic clear;
      logic update;
   } crc_ctrl_type;

endpackage

// File: rtl/crcfr_byte_cell.sv
// One byte cell of the frame shift chain.
// Depends on crcfr_pkg for the control struct.
module crcfr_byte_cell (
   input  logic                    clock,
   input  crcfr_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]              load_byte,
   input  logic [7:0]              next_byte,
   output logic [7:0]              byte_out
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // Load a new frame byte or take the neighbor's byte on a shift.
   always_comb begin
      byte_in = byte_ff;
      priority if (ctrl.load) begin
         byte_in = load_byte;
      end else if (ctrl.shift) begin
         byte_in = next_byte;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign byte_out = byte_ff;

endmodule

// File: rtl/crcfr_crc_cell.sv
// CRC-16/MODBUS accumulator cell at the head of the chain.
// Depends on crcfr_pkg for constants and the control struct.
module crcfr_crc_cell (
   input  logic                   clock,
   input  crcfr_pkg::crc_ctrl_type ctrl,
   input  logic [7:0]             data_in,
   output logic [15:0]            crc_out
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   // One byte of reflected CRC per cycle while update is set: eight shift-and-xor steps.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ crcfr_pkg::CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   always_comb begin
      crc_in = crc_ff;
      priority if (ctrl.clear) begin
         crc_in = crcfr_pkg::CRC_SEED;
      end else if (ctrl.update) begin
         crc_in = crc_byte(crc_ff, data_in);
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc_out = crc_ff;

endmodule

// File: rtl/can_frame_crc16_framer_unit.sv
// CAN log framer top level: byte cell chain, CRC cell and output register.
// Depends on crcfr_pkg, crcfr_byte_cell, crcfr_crc_cell and the assert header.
// A request loads the chain; the first frame byte then moves from the head cell into the output register.
// Output runs at one byte per cycle while the receiver is ready; a new message is taken as the last byte moves.
// Reset clears the busy flag and the output valid; no frame is in flight after it.
`include "can_frame_crc16_framer_unit_assert.svh"

module can_frame_crc16_framer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  crcfr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output crcfr_pkg::rsp_type rsp_data
);

   localparam int CHAIN_LEN = crcfr_pkg::CHAIN_LEN;
   localparam int POS_W     = crcfr_pkg::POS_W;

   logic             busy_ff, busy_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   crcfr_pkg::rsp_type rsp_ff, rsp_in;

   logic advance;
   logic frame_done;
   logic req_fire;

   crcfr_pkg::cell_ctrl_type cell_ctrl;
   crcfr_pkg::crc_ctrl_type  crc_ctrl;

   logic [7:0]  load_bytes [CHAIN_LEN];
   logic [7:0]  chain      [CHAIN_LEN];
   logic [15:0] crc_value;

   // While busy, the chain moves whenever the output register is free or being emptied.
   assign advance    = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign frame_done = advance && (pos_ff == crcfr_pkg::LAST_POS);
   assign req_ready  = !busy_ff || frame_done;
   assign req_fire   = req_valid && req_ready;

   assign cell_ctrl.load  = req_fire;
   assign cell_ctrl.shift = advance;

   assign crc_ctrl.clear  = req_fire;
   assign crc_ctrl.update = advance && (pos_ff >= crcfr_pkg::PAYLOAD_FIRST_POS)
                            && (pos_ff <= crcfr_pkg::PAYLOAD_LAST_POS);

   // Frame image: sync bytes, identifier big-endian, kinds, length, data, pad.
   always_comb begin
      load_bytes[0] = crcfr_pkg::SYNC_FIRST;
      load_bytes[1] = crcfr_pkg::SYNC_SECOND;
      load_bytes[2] = req_data.msg_id[31:24];
      load_bytes[3] = req_data.msg_id[23:16];
      load_bytes[4] = req_data.msg_id[15:8];
      load_bytes[5] = req_data.msg_id[7:0];
      load_bytes[6] = req_data.id_kind;
      load_bytes[7] = req_data.frame_kind;
      load_bytes[8] = req_data.length_code;
      for (int k = 0; k < 8; k++) begin
         load_bytes[9 + k] = req_data.data_bytes[63 - 8 * k -: 8];
      end
      for (int k = 17; k < CHAIN_LEN; k++) begin
         load_bytes[k] = 8'h00;
      end
   end

   // Row of byte cells; each shifts toward cell zero, the tail takes zero.
   for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
      logic [7:0] next_byte;
      if (i == CHAIN_LEN - 1) begin : g_tail
         assign next_byte = 8'h00;
      end else begin : g_body
         assign next_byte = chain[i + 1];
      end
      crcfr_byte_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .load_byte (load_bytes[i]),
         .next_byte (next_byte),
         .byte_out  (chain[i])
      );
   end

   // CRC over the payload bytes as they leave the head cell.
   crcfr_crc_cell u_crc (
      .clock   (clock),
      .ctrl    (crc_ctrl),
      .data_in (chain[0]),
      .crc_out (crc_value)
   );

   // Output register: head byte, then CRC low and high bytes.
   always_comb begin
      rsp_in = rsp_ff;
      if (advance) begin
         priority if (pos_ff == crcfr_pkg::LAST_POS) begin
            rsp_in.out_byte = crc_value[15:8];
         end else if (pos_ff == crcfr_pkg::CRC_LO_POS) begin
            rsp_in.out_byte = crc_value[7:0];
         end else begin
            rsp_in.out_byte = chain[0];
         end
         rsp_in.last_byte = (pos_ff == crcfr_pkg::LAST_POS);
      end
   end

   // Control next state.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      busy_in = busy_ff;
      pos_in  = pos_ff;
      priority if (req_fire) begin
         busy_in = 1'b1;
         pos_in  = '0;
      end else if (advance) begin
         busy_in = !frame_done;
         pos_in  = pos_ff + POS_W'(1);
      end else begin
         busy_in = busy_ff;
         pos_in  = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A moved final byte shows up as a valid, marked transaction.
   `CRCFR_ASSERT_NEXT(a_last_marked, clock, reset, frame_done, rsp_valid && rsp_data.last_byte)
   // An accepted request starts a frame at position zero.
   `CRCFR_ASSERT_NEXT(a_start_frame, clock, reset, req_fire, busy_ff && (pos_ff == '0))
   // A freshly loaded chain presents the first sync byte at its head.
   `CRCFR_ASSERT_NOW(a_sync_head, clock, reset, busy_ff && (pos_ff == '0), chain[0] == crcfr_pkg::SYNC_FIRST)
   // Only the final byte carries the last mark.
   `CRCFR_ASSERT_NEXT(a_mark_only_last, clock, reset, advance && !frame_done, !rsp_data.last_byte)

endmodule

// File: bench/log_frame_monitor.sv
// Frame monitor for the CAN log framer: watches both channels and checks every output byte.
// Depends on crcfr_pkg for the transaction types and the frame constants.
`timescale 1ns / 1ps

module log_frame_monitor
   import crcfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_bytes
);

   // Frame bytes still owed by the block, oldest first.
   rsp_type frame_bytes_owed[$];

   initial begin
      fail_count    = 0;
      pending_bytes = 0;
   end

   // One byte step of CRC-16/MODBUS, LSB first with the reflected polynomial.
   function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc_in,
                                                    input logic [7:0]  data_in);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data_in};
      for (int k = 0; k < 8; k++) begin
         crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
      return crc;
   endfunction

   // Queue up the whole 24-byte log frame that one message must produce.
   function automatic void queue_log_frame(input req_type msg);
      logic [7:0]  payload [PAYLOAD_LEN];
      logic [15:0] crc;
      rsp_type     entry;
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         payload[i] = 8'h00;
      end
      payload[0] = msg.msg_id[31:24];
      payload[1] = msg.msg_id[23:16];
      payload[2] = msg.msg_id[15:8];
      payload[3] = msg.msg_id[7:0];
      payload[4] = msg.id_kind;
      payload[5] = msg.frame_kind;
      payload[6] = msg.length_code;
      for (int i = 0; i < 8; i++) begin
         payload[7 + i] = msg.data_bytes[63 - 8 * i -: 8];
      end

      crc = CRC_SEED;
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         crc = modbus_crc_byte(crc, payload[i]);
      end

      entry.last_byte = 1'b0;
      entry.out_byte  = SYNC_FIRST;
      frame_bytes_owed.push_back(entry);
      entry.out_byte  = SYNC_SECOND;
      frame_bytes_owed.push_back(entry);
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         entry.out_byte = payload[i];
         frame_bytes_owed.push_back(entry);
      end
      entry.out_byte = crc[7:0];
      frame_bytes_owed.push_back(entry);
      entry.out_byte  = crc[15:8];
      entry.last_byte = 1'b1;
      frame_bytes_owed.push_back(entry);
   endfunction

   // Compare each output transaction with the oldest owed byte, then record new requests.
   always @(posedge clock) begin
      rsp_type owed;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (frame_bytes_owed.size() == 0) begin
               $error("unexpected output byte %h (last %b) with nothing owed",
                      rsp_data.out_byte, rsp_data.last_byte);
               fail_count++;
            end else begin
               owed = frame_bytes_owed.pop_front();
               if (rsp_data.out_byte !== owed.out_byte) begin
                  $error("out_byte: expected %h, actual %h", owed.out_byte,
                         rsp_data.out_byte);
                  fail_count++;
               end
               if (rsp_data.last_byte !== owed.last_byte) begin
                  $error("last_byte: expected %b, actual %b", owed.last_byte,
                         rsp_data.last_byte);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            queue_log_frame(req_data);
         end
      end
      pending_bytes = frame_bytes_owed.size();
   end

endmodule

// File: bench/testbench.sv
// Top of the CAN log framer bench: clock, reset, message stimulus and the verdict.
// Depends on crcfr_pkg, can_frame_crc16_framer_unit and log_frame_monitor.
`timescale 1ns / 1ps

module testbench;
   import crcfr_pkg::*;

   localparam int RANDOM_MESSAGES = 220;
   localparam int CYCLE_LIMIT     = 100000;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 30;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_bytes;

   // Idling control: quiet_phase is shared by the sender and the receiver; the hold flags serve the receiver.
   bit quiet_phase;
   bit hold_wanted;
   bit hold_done;
   int hold_left;
   int cycle_count;

   can_frame_crc16_framer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   log_frame_monitor u_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_bytes (pending_bytes)
   );

   // 2 ns clock.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Give every block input a known value from time zero.
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      quiet_phase = 1'b0;
      hold_wanted = 1'b0;
      hold_done   = 1'b0;
      hold_left   = 0;
      cycle_count = 0;
   end

   // Run limit in case the block stops moving.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: random back-pressure, one long hold-off and a stretch with none.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_wanted && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (quiet_phase) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 13);
      end
   end

   function automatic req_type make_message(input logic [31:0] id, input logic [7:0] id_kind,
                                            input logic [7:0] frame_kind,
                                            input logic [7:0] length_code,
                                            input logic [63:0] data);
      req_type msg;
      msg.msg_id      = id;
      msg.id_kind     = id_kind;
      msg.frame_kind  = frame_kind;
      msg.length_code = length_code;
      msg.data_bytes  = data;
      return msg;
   endfunction

   // Offer one message, with an occasional gap before it, and wait for its transaction.
   task automatic send_message(input req_type msg);
      if (!quiet_phase && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= msg;
      do @(posedge clock); while (!req_ready);
   endtask

   // Random message: mostly plausible CAN traffic, the rest raw noise in every field.
   function automatic req_type random_message();
      req_type msg;
      msg.data_bytes = {$urandom, $urandom};
      if ($urandom_range(99) < 70) begin
         msg.id_kind     = 8'($urandom_range(1));
         msg.frame_kind  = 8'($urandom_range(1));
         msg.length_code = 8'($urandom_range(8));
         msg.msg_id      = msg.id_kind[0] ? ($urandom & 32'h1FFF_FFFF)
                                          : ($urandom & 32'h0000_07FF);
      end else begin
         msg.msg_id      = $urandom;
         msg.id_kind     = 8'($urandom);
         msg.frame_kind  = 8'($urandom);
         msg.length_code = 8'($urandom);
      end
      return msg;
   endfunction

   // Stimulus and verdict.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed messages: field extremes, typical frames and length codes above eight.
      send_message(make_message(32'h0, 8'h00, 8'h00, 8'h00, 64'h0));
      send_message(make_message(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF));
      send_message(make_message(32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 64'h0));
      send_message(make_message(32'h0, 8'h00, 8'h00, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF));
      send_message(make_message(32'h0000_0001, 8'h00, 8'h00, 8'h08, 64'h0102_0304_0506_0708));
      send_message(make_message(32'h8000_0000, 8'h01, 8'h01, 8'h00, 64'h8000_0000_0000_0001));
      send_message(make_message(32'h0000_07FF, 8'h00, 8'h00, 8'h08, 64'hDEAD_BEEF_CAFE_F00D));
      send_message(make_message(32'h1FFF_FFFF, 8'h01, 8'h00, 8'h08, 64'h1122_3344_5566_7788));
      send_message(make_message(32'h1FFF_FFFF, 8'h01, 8'h01, 8'h00, 64'h0));
      send_message(make_message(32'h0000_0123, 8'h00, 8'h00, 8'h09, 64'h0123_4567_89AB_CDEF));
      send_message(make_message(32'h0000_0456, 8'h00, 8'h00, 8'h0F, 64'hFEDC_BA98_7654_3210));
      send_message(make_message(32'h0000_0789, 8'h00, 8'h00, 8'hFF, 64'h00FF_00FF_00FF_00FF));
      send_message(make_message(32'hAAAA_AAAA, 8'hAA, 8'hAA, 8'hAA, 64'hAAAA_AAAA_AAAA_AAAA));
      send_message(make_message(32'h5555_5555, 8'h55, 8'h55, 8'h55, 64'h5555_5555_5555_5555));
      send_message(make_message(32'h0000_00AA, 8'h55, 8'h00, 8'h02, 64'hAA55_0000_0000_0000));
      send_message(make_message(32'h0000_0000, 8'h01, 8'h80, 8'h80, 64'h0000_0000_0000_0080));

      // Random messages with one long receiver hold-off and one stretch without idling.
      for (int n = 0; n < RANDOM_MESSAGES; n++) begin
         if (n == 30) begin
            hold_wanted <= 1'b1;
         end
         if (n == 90) begin
            quiet_phase <= 1'b1;
         end
         if (n == 150) begin
            quiet_phase <= 1'b0;
         end
         send_message(random_message());
      end
      req_valid <= 1'b0;

      // Drain every owed byte, then allow a few more cycles for stray output.
      @(posedge clock);
      while (pending_bytes != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_bytes == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
